// ===== rtl/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants of the rational arithmetic unit: operation
// codes, datapath command and status bundles, field widths.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int FIELD_BITS     = 32;
  localparam int OP_BITS        = 3;
  localparam int IN_TDATA_BITS  = 136;
  localparam int OUT_TDATA_BITS = 72;
  localparam int ZERO_MARK      = -9999;

  typedef enum logic [OP_BITS-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_RED = 3'd4
  } op_t;

  // multiplier operand pairs
  typedef enum logic [2:0] {
    MS_AD,
    MS_CB,
    MS_BD,
    MS_AC,
    MS_BC
  } mul_sel_t;

  // divider operand pairs
  typedef enum logic [1:0] {
    DS_GCD,
    DS_QN,
    DS_QD
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     div_start;
    div_sel_t div_sel;
    logic     gcd_step;
    logic     save_qn;
    logic     finish;
  } rau_cmd_t;

  typedef struct packed {
    op_t  op;
    logic x_zero;
    logic y_zero;
    logic div_done;
    logic div_busy;
  } rau_stat_t;

endpackage

// ===== rtl/rau_divider.sv =====
// ----------------------------------------------------------------------------
// rau_divider
// Iterative signed divider, one quotient bit per cycle, truncating toward
// zero; the remainder takes the sign of the dividend.
// ----------------------------------------------------------------------------
module rau_divider #(
  parameter int W = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [W-1:0] dividend,
  input  logic signed [W-1:0] divisor,
  output logic                busy,
  output logic                done,
  output logic signed [W:0]   quo,
  output logic signed [W-1:0] rem
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  dsr_r;
  logic          neg_q_r, neg_r_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;

  logic [W-1:0]  dd_mag, ds_mag;
  logic [W:0]    sh, diff;
  logic          ge;

  assign dd_mag = dividend[W-1] ? (~dividend + 1'b1) : dividend;
  assign ds_mag = divisor[W-1]  ? (~divisor + 1'b1)  : divisor;

  assign sh      = {rem_r, quo_r[W-1]};
  assign ge      = (sh >= {1'b0, dsr_r});
  assign diff    = sh - {1'b0, dsr_r};
  assign rem_nxt = ge ? diff[W-1:0] : sh[W-1:0];
  assign quo_nxt = {quo_r[W-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r   <= '0;
      quo_r   <= dd_mag;
      dsr_r   <= ds_mag;
      neg_q_r <= dividend[W-1] ^ divisor[W-1];
      neg_r_r <= dividend[W-1];
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = neg_q_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
  assign rem  = neg_r_r ? -$signed(rem_r) : $signed(rem_r);

endmodule

// ===== rtl/rau_datapath.sv =====
// ----------------------------------------------------------------------------
// rau_datapath
// Operand registers, shared signed multiplier with a three-deep product
// line, euclid registers with the iterative divider, and the result register.
// ----------------------------------------------------------------------------
module rau_datapath
  import rau_pkg::*;
#(
  parameter int W = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  op_t                 in_op,
  input  logic signed [W-1:0] in_a,
  input  logic signed [W-1:0] in_b,
  input  logic signed [W-1:0] in_c,
  input  logic signed [W-1:0] in_d,
  input  rau_cmd_t            cmd,
  output rau_stat_t           stat,
  output logic signed [W-1:0] res_num,
  output logic signed [W-1:0] res_den,
  output logic                res_ovf
);

  localparam logic signed [FIELD_BITS-1:0] ZM_FULL = FIELD_BITS'(ZERO_MARK);
  localparam logic [W-1:0] ZM_W   = ZM_FULL[W-1:0];
  localparam bit           ZM_OVF = (longint'(ZERO_MARK) < -(64'sd1 <<< (W - 1)));

  op_t                  op_r;
  logic signed [W-1:0]  a_r, b_r, c_r, d_r;
  logic signed [W-1:0]  x_r, y_r;
  logic signed [2*W-1:0] prod_r, prev_r, prev2_r;
  logic signed [W:0]    qn_r;
  logic signed [W-1:0]  res_num_r, res_den_r;
  logic                 res_ovf_r;

  logic signed [W-1:0]  mx, my;
  logic signed [W-1:0]  dv_dd, dv_ds;
  logic                 dv_busy, dv_done;
  logic signed [W:0]    dv_quo;
  logic signed [W-1:0]  dv_rem;

  logic signed [2*W:0]  sum_v;
  logic                 sum_fit, prod_fit, prev_fit, qn_fit, qd_fit;
  logic signed [W-1:0]  num_nxt, den_nxt;
  logic                 ovf_nxt;

  always_comb begin
    case (cmd.mul_sel)
      MS_AD:   begin mx = a_r; my = d_r; end
      MS_CB:   begin mx = c_r; my = b_r; end
      MS_BD:   begin mx = b_r; my = d_r; end
      MS_AC:   begin mx = a_r; my = c_r; end
      MS_BC:   begin mx = b_r; my = c_r; end
      default: begin mx = a_r; my = d_r; end
    endcase
  end

  always_comb begin
    case (cmd.div_sel)
      DS_GCD:  begin dv_dd = x_r; dv_ds = y_r; end
      DS_QN:   begin dv_dd = a_r; dv_ds = x_r; end
      DS_QD:   begin dv_dd = b_r; dv_ds = x_r; end
      default: begin dv_dd = x_r; dv_ds = y_r; end
    endcase
  end

  rau_divider #(.W(W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dv_dd),
    .divisor  (dv_ds),
    .busy     (dv_busy),
    .done     (dv_done),
    .quo      (dv_quo),
    .rem      (dv_rem)
  );

  // add and subtract leave a*d in prev2, c*b in prev and b*d in prod
  always_comb begin
    if (op_r == OP_SUB) begin
      sum_v = (2*W+1)'(prev2_r) - (2*W+1)'(prev_r);
    end else begin
      sum_v = (2*W+1)'(prev2_r) + (2*W+1)'(prev_r);
    end
  end

  assign sum_fit  = (&sum_v[2*W:W-1]) | ~(|sum_v[2*W:W-1]);
  assign prod_fit = (&prod_r[2*W-1:W-1]) | ~(|prod_r[2*W-1:W-1]);
  assign prev_fit = (&prev_r[2*W-1:W-1]) | ~(|prev_r[2*W-1:W-1]);
  assign qn_fit   = (qn_r[W] == qn_r[W-1]);
  assign qd_fit   = (dv_quo[W] == dv_quo[W-1]);

  always_comb begin
    case (op_r)
      OP_ADD, OP_SUB: begin
        num_nxt = sum_v[W-1:0];
        den_nxt = prod_r[W-1:0];
        ovf_nxt = !sum_fit || !prod_fit;
      end
      OP_MUL, OP_DIV: begin
        num_nxt = prev_r[W-1:0];
        den_nxt = prod_r[W-1:0];
        ovf_nxt = !prev_fit || !prod_fit;
      end
      OP_RED: begin
        if (x_r == '0) begin
          num_nxt = ZM_W;
          den_nxt = W'(1);
          ovf_nxt = ZM_OVF;
        end else begin
          num_nxt = qn_r[W-1:0];
          den_nxt = dv_quo[W-1:0];
          ovf_nxt = !qn_fit || !qd_fit;
        end
      end
      default: begin
        num_nxt = '0;
        den_nxt = W'(1);
        ovf_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_op;
      a_r  <= in_a;
      b_r  <= in_b;
      c_r  <= in_c;
      d_r  <= in_d;
      x_r  <= in_a;
      y_r  <= in_b;
    end else if (cmd.gcd_step) begin
      x_r <= y_r;
      y_r <= dv_rem;
    end
    if (cmd.mul_en) begin
      prod_r  <= mx * my;
      prev_r  <= prod_r;
      prev2_r <= prev_r;
    end
    if (cmd.save_qn) begin
      qn_r <= dv_quo;
    end
    if (cmd.finish) begin
      res_num_r <= num_nxt;
      res_den_r <= den_nxt;
      res_ovf_r <= ovf_nxt;
    end
  end

  assign stat.op       = op_r;
  assign stat.x_zero   = (x_r == '0);
  assign stat.y_zero   = (y_r == '0);
  assign stat.div_done = dv_done;
  assign stat.div_busy = dv_busy;

  assign res_num = res_num_r;
  assign res_den = res_den_r;
  assign res_ovf = res_ovf_r;

endmodule

// ===== rtl/rau_ctrl.sv =====
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer: steps the multiplier for the arithmetic ops, runs the euclid
// loop and the two final divisions for reduce, and owns the result valid.
// ----------------------------------------------------------------------------
module rau_ctrl
  import rau_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  op_t       in_op,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  rau_stat_t stat,
  output rau_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_GCD,
    S_GCD_WAIT,
    S_QN,
    S_QN_WAIT,
    S_QD,
    S_QD_WAIT,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          case (in_op)
            OP_RED:                         state_nxt = S_GCD;
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: state_nxt = S_MUL1;
            default:                        state_nxt = S_FIN;
          endcase
        end
      end
      S_MUL1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = (stat.op == OP_MUL) ? MS_AC : MS_AD;
        state_nxt   = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_en = 1'b1;
        case (stat.op)
          OP_MUL: begin
            cmd.mul_sel = MS_BD;
            state_nxt   = S_FIN;
          end
          OP_DIV: begin
            cmd.mul_sel = MS_BC;
            state_nxt   = S_FIN;
          end
          default: begin
            cmd.mul_sel = MS_CB;
            state_nxt   = S_MUL3;
          end
        endcase
      end
      S_MUL3: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_BD;
        state_nxt   = S_FIN;
      end
      S_GCD: begin
        if (stat.y_zero) begin
          // gcd is x; zero over zero skips the divisions
          state_nxt = stat.x_zero ? S_FIN : S_QN;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DS_GCD;
          state_nxt     = S_GCD_WAIT;
        end
      end
      S_GCD_WAIT: begin
        cmd.div_sel = DS_GCD;
        if (stat.div_done) begin
          cmd.gcd_step = 1'b1;
          state_nxt    = S_GCD;
        end
      end
      S_QN: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DS_QN;
        state_nxt     = S_QN_WAIT;
      end
      S_QN_WAIT: begin
        cmd.div_sel = DS_QN;
        if (stat.div_done) begin
          cmd.save_qn = 1'b1;
          state_nxt   = S_QD;
        end
      end
      S_QD: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DS_QD;
        state_nxt     = S_QD_WAIT;
      end
      S_QD_WAIT: begin
        cmd.div_sel = DS_QD;
        if (stat.div_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/rational_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// add, subtract, multiply and divide of two fractions, and gcd reduction of
// the first; one item at a time through a sequencer and a shared datapath.
// ----------------------------------------------------------------------------
// add/sub step the multiplier in S_MUL1 to S_MUL3, mul/div in S_MUL1 and S_MUL2;
// unused ops go straight to S_FIN; reduce runs k euclid remainder steps
//   (up to about 46 at 32 bits) on the iterative divider
// one item in flight; the next is taken while the last result waits
// rst_n synchronous: clears the sequencer, the result valid and the divider control only
module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int WORD_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // op, first_num, first_den, second_num, second_den
  input  logic [IN_TDATA_BITS-1:0]  in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // result_num, result_den, overflow
  output logic [OUT_TDATA_BITS-1:0] out_tdata
);

  localparam int W = WORD_BITS;

  rau_cmd_t            cmd;
  rau_stat_t           stat;
  op_t                 in_op;
  logic signed [W-1:0] res_num, res_den;
  logic                res_ovf;
  logic signed [FIELD_BITS-1:0] num_ext, den_ext;

  assign in_op = op_t'(in_tdata[2:0]);

  rau_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_op     (in_op),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rau_datapath #(.W(W)) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_op   (in_op),
    .in_a    (in_tdata[3 +: W]),
    .in_b    (in_tdata[35 +: W]),
    .in_c    (in_tdata[67 +: W]),
    .in_d    (in_tdata[99 +: W]),
    .cmd     (cmd),
    .stat    (stat),
    .res_num (res_num),
    .res_den (res_den),
    .res_ovf (res_ovf)
  );

  assign num_ext   = FIELD_BITS'(res_num);
  assign den_ext   = FIELD_BITS'(res_den);
  assign out_tdata = {7'd0, res_ovf, den_ext, num_ext};

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while one is in flight");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result raised without an item in work");

  a_div_idle_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !stat.div_busy)
    else $error("divider busy while accepting");

endmodule
